// ----- hdl/bsmt_pkg.sv -----
// shared types and constants of the backing-store map table
package bsmt_pkg;

    localparam int OWNER_W  = 6;
    localparam int PAGE_W   = 20;
    localparam int COUNT_W  = 9;
    localparam int ADDR_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int OFFSET_W = 21;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_MAP    = 2'd2,
        OP_UNMAP  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pages;
        logic [PAGE_W-1:0]  base_page;
        logic [OWNER_W-1:0] owner;
    } entry_t;

endpackage

// ----- hdl/bsmt_store.sv -----
// entry memory: one write port, one registered read port
module bsmt_store #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  bsmt_pkg::entry_t    wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output bsmt_pkg::entry_t    rd_data
);

    bsmt_pkg::entry_t mem [DEPTH];
    bsmt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/backing_store_map_table_unit.sv -----
// top level of the backing-store map table
// One request per transfer, one result per request. Allocate and map go from the request
// transfer straight to the response state, which loads the output register once it is free;
// lookup and unmap walk the entry memory from entry 0 through its single read port, with a
// read state and a check state per entry visited, until a hit or the last entry (at most
// NUM_STORES entries are visited). The next request is taken only once the previous result
// has entered the output register, so a held result that blocks the output register also
// holds off new requests. Mapped flags live in flip-flops cleared by reset, so the table is
// usable right after reset with no clearing pass; owner, base page and page count sit in the
// entry memory and are read for every entry visited but only used for mapped entries.
module backing_store_map_table_unit #(
    parameter int NUM_STORES = 8,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // process_id[5:0], virtual_address[37:6], virtual_page[57:38], store_index[61:58],
    // page_count[70:62], zero fill
    input  logic [71:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found_index[3:0], page_offset[24:4], zero fill
    output logic [31:0] m_axis_tdata,
    // status[0]
    output logic        m_axis_tuser
);

    localparam int IDX_W = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } state_t;

    // input field unpacking
    bsmt_pkg::opcode_t                   in_opcode;
    logic [bsmt_pkg::OWNER_W-1:0]        in_pid;
    logic [bsmt_pkg::ADDR_W-1:0]         in_vaddr;
    logic [bsmt_pkg::PAGE_W-1:0]         in_vpage;
    logic [bsmt_pkg::INDEX_W-1:0]        in_sidx;
    logic [bsmt_pkg::COUNT_W-1:0]        in_npages;

    assign in_opcode = bsmt_pkg::opcode_t'(s_axis_tuser);
    assign in_pid    = s_axis_tdata[5:0];
    assign in_vaddr  = s_axis_tdata[37:6];
    assign in_vpage  = s_axis_tdata[57:38];
    assign in_sidx   = s_axis_tdata[61:58];
    assign in_npages = s_axis_tdata[70:62];

    state_t                          state_reg;
    bsmt_pkg::opcode_t               op_reg;
    logic [bsmt_pkg::OWNER_W-1:0]    pid_reg;
    logic [bsmt_pkg::OFFSET_W-1:0]   vpn_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [NUM_STORES-1:0]           mapped_reg;
    logic                            res_status_reg;
    logic [bsmt_pkg::INDEX_W-1:0]    res_index_reg;
    logic [bsmt_pkg::OFFSET_W-1:0]   res_offset_reg;
    logic                            m_valid_reg;
    logic                            m_status_reg;
    logic [bsmt_pkg::INDEX_W-1:0]    m_index_reg;
    logic [bsmt_pkg::OFFSET_W-1:0]   m_offset_reg;

    logic                            s_accept;
    logic                            map_ok;
    logic                            wr_en;
    logic                            free_found;
    logic [IDX_W-1:0]                free_idx;
    logic                            hit;
    logic                            last_entry;
    logic                            out_free;
    logic [bsmt_pkg::OFFSET_W-1:0]   offset_calc;
    bsmt_pkg::entry_t                wr_entry;
    bsmt_pkg::entry_t                rd_entry;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign map_ok        = ({1'b0, in_sidx} < 5'(NUM_STORES));
    assign wr_en         = s_accept && (in_opcode == bsmt_pkg::OP_MAP) && map_ok;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign wr_entry.owner     = in_pid;
    assign wr_entry.base_page = in_vpage;
    assign wr_entry.pages     = in_npages;

    bsmt_store #(
        .DEPTH (NUM_STORES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_sidx[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    // lowest unmapped entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = NUM_STORES - 1; k >= 0; k--)
        begin
            if (!mapped_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    assign hit         = mapped_reg[idx_reg] && (rd_entry.owner == pid_reg);
    assign last_entry  = (idx_reg == IDX_W'(NUM_STORES - 1));
    assign offset_calc = vpn_reg - {1'b0, rd_entry.base_page};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= bsmt_pkg::OP_ALLOC;
            pid_reg        <= '0;
            vpn_reg        <= '0;
            idx_reg        <= '0;
            mapped_reg     <= '0;
            res_status_reg <= bsmt_pkg::STATUS_ERR;
            res_index_reg  <= '0;
            res_offset_reg <= '0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= bsmt_pkg::STATUS_ERR;
            m_index_reg    <= '0;
            m_offset_reg   <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && (state_reg != ST_RESP))
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        op_reg         <= in_opcode;
                        pid_reg        <= in_pid;
                        vpn_reg        <= bsmt_pkg::OFFSET_W'(in_vaddr >> PAGE_SHIFT);
                        idx_reg        <= '0;
                        res_offset_reg <= '0;
                        unique case (in_opcode)
                            bsmt_pkg::OP_ALLOC:
                            begin
                                res_status_reg <= free_found ? bsmt_pkg::STATUS_OK
                                                             : bsmt_pkg::STATUS_ERR;
                                res_index_reg  <= free_found ? bsmt_pkg::INDEX_W'(free_idx)
                                                             : '0;
                                state_reg      <= ST_RESP;
                            end
                            bsmt_pkg::OP_MAP:
                            begin
                                if (map_ok)
                                begin
                                    mapped_reg[in_sidx[IDX_W-1:0]] <= 1'b1;
                                end
                                res_status_reg <= map_ok ? bsmt_pkg::STATUS_OK
                                                         : bsmt_pkg::STATUS_ERR;
                                res_index_reg  <= '0;
                                state_reg      <= ST_RESP;
                            end
                            default:
                            begin
                                res_status_reg <= bsmt_pkg::STATUS_ERR;
                                res_index_reg  <= '0;
                                state_reg      <= ST_READ;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (hit)
                    begin
                        res_status_reg <= bsmt_pkg::STATUS_OK;
                        if (op_reg == bsmt_pkg::OP_LOOKUP)
                        begin
                            res_index_reg  <= bsmt_pkg::INDEX_W'(idx_reg);
                            res_offset_reg <= offset_calc;
                        end
                        else
                        begin
                            mapped_reg[idx_reg] <= 1'b0;
                        end
                        state_reg <= ST_RESP;
                    end
                    else if (last_entry)
                    begin
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_index_reg  <= res_index_reg;
                        m_offset_reg <= res_offset_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_offset_reg, m_index_reg};
    assign m_axis_tuser  = m_status_reg;

    // a good map leaves its entry marked mapped
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> mapped_reg[$past(in_sidx[IDX_W-1:0])])
        else $error("mapped flag not set after map");

    // results appear only out of the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

    // a loaded response returns the unit to taking requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && out_free) |=> s_axis_tready)
        else $error("unit did not return to idle after response");

    // an unmap hit clears the entry it found
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && hit && op_reg == bsmt_pkg::OP_UNMAP)
            |=> !mapped_reg[$past(idx_reg)])
        else $error("unmap left entry mapped");

endmodule
